// File: rtl/lgre_pkg.sv
// shared types, constants and helpers for the life generation raster engine
// depends on nothing; imported by every module of the block
`default_nettype none

package lgre_pkg;

    // grid geometry
    localparam int MAX_GRID   = 32;
    localparam int GRID_MIN   = 3;
    localparam int IDX_W      = $clog2(MAX_GRID);
    localparam int SIZE_W     = 6;
    localparam int FIDX_W     = IDX_W + 1;

    // result fields
    localparam int POP_W      = 11;
    localparam int GEN_W      = 32;
    localparam int OUT_BITS   = 1 + 2 * IDX_W + POP_W + GEN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GEN   = 1'b1;
    localparam logic [SIZE_W-1:0]    GRID_SIZE_RST = 6'd25;
    localparam logic [GEN_W-1:0]     MAX_GEN_RST   = 32'd1000000;

    // queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    // one classified input cell
    typedef struct packed {
        logic             alive;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] last_col;
        logic             first;
    } t_entry;

    // one window column: above, middle, below
    typedef logic [2:0] t_wcol;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT_A,
        S_EMIT_B,
        S_FILL,
        S_FLUSH
    } t_back_state;

    // last column index for a requested side, clamped to the supported range
    function automatic logic [IDX_W-1:0] last_col_of(input logic [SIZE_W-1:0] gs);
        logic [IDX_W-1:0] res;
        if (gs < SIZE_W'(GRID_MIN)) begin
            res = IDX_W'(GRID_MIN - 1);
        end else if (gs > SIZE_W'(MAX_GRID)) begin
            res = IDX_W'(MAX_GRID - 1);
        end else begin
            res = IDX_W'(gs - SIZE_W'(1));
        end
        return res;
    endfunction

    // b3/s23 rule over a 3x3 window given as left, center and right columns
    function automatic logic life_next(input t_wcol l, input t_wcol c, input t_wcol r);
        logic [3:0] cnt;
        cnt = 4'(l[2]) + 4'(l[1]) + 4'(l[0]) + 4'(c[2]) + 4'(c[0])
            + 4'(r[2]) + 4'(r[1]) + 4'(r[0]);
        return (cnt == 4'd3) || (c[1] && cnt == 4'd2);
    endfunction

endpackage

`default_nettype wire

// File: rtl/lgre_front.sv
// front end: accepts input cells, tracks raster position and grid side
// depends on lgre_pkg; feeds lgre_fifo
`default_nettype none

module lgre_front
    import lgre_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_alive,
    input  wire logic [SIZE_W-1:0] i_grid_size,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_entry                 o_entry
);

    logic [IDX_W-1:0] r_in_row, n_in_row;
    logic [IDX_W-1:0] r_in_col, n_in_col;
    logic [IDX_W-1:0] r_last, n_last;
    logic             first;
    logic [IDX_W-1:0] last_now;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // side is sampled on the first cell of each grid
    assign first    = (r_in_row == '0) && (r_in_col == '0);
    assign last_now = first ? last_col_of(i_grid_size) : r_last;

    always_comb begin
        o_entry.alive    = i_alive;
        o_entry.row      = r_in_row;
        o_entry.col      = r_in_col;
        o_entry.last_col = last_now;
        o_entry.first    = first;
    end

    // raster advance
    always_comb begin
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        n_last   = r_last;
        if (o_push) begin
            n_last = last_now;
            if (r_in_col == last_now) begin
                n_in_col = '0;
                n_in_row = (r_in_row == last_now) ? '0 : r_in_row + IDX_W'(1);
            end else begin
                n_in_col = r_in_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_last   <= last_col_of(GRID_SIZE_RST);
        end else begin
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
            r_last   <= n_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lgre_fifo.sv
// short queue of classified cells between front and back end
// depends on lgre_pkg
`default_nettype none

module lgre_fifo
    import lgre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_entry    i_entry,
    output logic      o_full,
    input  wire logic i_pop,
    output t_entry    o_entry,
    output logic      o_empty
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/lgre_back.sv
// back end: line stores, 3x3 window, rule evaluation, flush and counters
// depends on lgre_pkg; drains lgre_fifo and drives the result stream
`default_nettype none

module lgre_back
    import lgre_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  t_entry                      i_entry,
    output logic                        o_pop,
    input  wire logic [GEN_W-1:0]       i_max_gen,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tlast,
    output logic                        o_m_tuser
);

    t_back_state r_state, n_state;

    // current item
    logic [IDX_W-1:0] r_row, r_col, r_lastc;

    // window and flush indexes
    t_wcol             r_w0, r_w1, r_w2, n_w0, n_w1, n_w2;
    logic [FIDX_W-1:0] r_fidx, n_fidx;
    logic [IDX_W-1:0]  r_ecol, n_ecol;

    // line stores
    logic [MAX_GRID-1:0] r_upper, r_lower, r_cur, n_upper, n_lower, n_cur;

    // counters
    logic [POP_W-1:0] r_live, n_live;
    logic [GEN_W-1:0] r_gen, n_gen;

    // output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_alive, n_out_alive;
    logic [IDX_W-1:0] r_out_row, n_out_row;
    logic [IDX_W-1:0] r_out_col, n_out_col;
    logic             r_out_last, n_out_last;
    logic             r_out_done, n_out_done;
    logic [POP_W-1:0] r_out_pop, n_out_pop;
    logic [GEN_W-1:0] r_out_gen, n_out_gen;

    logic       out_free;
    logic       pop;
    logic       em_a_new, em_b, fin, fl_last;
    t_wcol      col_new, col_fl, win_l, win_c, win_r;
    logic       nxt;
    logic [POP_W-1:0] live_inc;
    logic [GEN_W-1:0] gen_inc, gen_new;

    assign out_free = !r_out_valid || i_m_tready;
    assign pop      = (r_state == S_IDLE) && !i_empty;
    assign o_pop    = pop;

    // classification of the popped and the held item
    assign em_a_new = (i_entry.row != '0) && (i_entry.col != '0);
    assign em_b     = (r_col == r_lastc);
    assign fin      = (r_row == r_lastc) && (r_col == r_lastc);
    assign fl_last  = (r_ecol == r_lastc);

    // column entering the window for a new cell
    assign col_new = {(i_entry.row > IDX_W'(1)) ? r_upper[i_entry.col] : 1'b0,
                      r_lower[i_entry.col], i_entry.alive};

    // column entering the window during the bottom-row flush
    assign col_fl = (r_fidx <= {1'b0, r_lastc}) ?
                    {r_lower[r_fidx[IDX_W-1:0]], r_cur[r_fidx[IDX_W-1:0]], 1'b0} : 3'b000;

    // window taps for the cell being emitted
    always_comb begin
        win_l = r_w0;
        win_c = r_w1;
        win_r = r_w2;
        if (r_state == S_EMIT_B) begin
            win_l = r_w1;
            win_c = r_w2;
            win_r = 3'b000;
        end
    end

    assign nxt      = life_next(win_l, win_c, win_r);
    assign live_inc = r_live + POP_W'(nxt);
    assign gen_inc  = r_gen + GEN_W'(1);
    assign gen_new  = (gen_inc == i_max_gen) ? '0 : gen_inc;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop && em_a_new) begin
                    n_state = S_EMIT_A;
                end
            end
            S_EMIT_A: begin
                if (out_free) begin
                    n_state = em_b ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B: begin
                if (out_free) begin
                    n_state = fin ? S_FILL : S_IDLE;
                end
            end
            S_FILL: begin
                if (r_fidx == FIDX_W'(1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free && fl_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic emit;
        logic done;
        emit        = 1'b0;
        done        = 1'b0;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_fidx      = r_fidx;
        n_ecol      = r_ecol;
        n_upper     = r_upper;
        n_lower     = r_lower;
        n_cur       = r_cur;
        n_live      = r_live;
        n_gen       = r_gen;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_alive = r_out_alive;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        n_out_pop   = r_out_pop;
        n_out_gen   = r_out_gen;

        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    n_cur[i_entry.col] = i_entry.alive;
                    if (i_entry.first) begin
                        n_live = '0;
                    end
                    if (i_entry.col == '0) begin
                        n_w0 = 3'b000;
                        n_w1 = 3'b000;
                    end else begin
                        n_w0 = r_w1;
                        n_w1 = r_w2;
                    end
                    n_w2 = col_new;
                    done = !em_a_new;
                end
            end
            S_EMIT_A: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_out_row  = r_row - IDX_W'(1);
                    n_out_col  = r_col - IDX_W'(1);
                    n_out_last = !em_b;
                    done       = !em_b;
                end
            end
            S_EMIT_B: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_out_row  = r_row - IDX_W'(1);
                    n_out_col  = r_col;
                    n_out_last = !fin;
                    done       = !fin;
                    if (fin) begin
                        n_w0   = 3'b000;
                        n_w1   = 3'b000;
                        n_w2   = 3'b000;
                        n_fidx = '0;
                    end
                end
            end
            S_FILL: begin
                n_w0   = r_w1;
                n_w1   = r_w2;
                n_w2   = col_fl;
                n_fidx = r_fidx + FIDX_W'(1);
                n_ecol = '0;
            end
            S_FLUSH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_out_row  = r_row;
                    n_out_col  = r_ecol;
                    n_out_last = fl_last;
                    n_w0       = r_w1;
                    n_w1       = r_w2;
                    n_w2       = col_fl;
                    n_fidx     = r_fidx + FIDX_W'(1);
                    n_ecol     = r_ecol + IDX_W'(1);
                    done       = fl_last;
                    if (fl_last) begin
                        n_gen      = gen_new;
                        n_out_done = 1'b1;
                        n_out_pop  = live_inc;
                        n_out_gen  = gen_new;
                    end
                end
            end
            default: begin
            end
        endcase

        // common part of every emitted result
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_alive = nxt;
            n_live      = live_inc;
            if (!(r_state == S_FLUSH && fl_last)) begin
                n_out_done = 1'b0;
                n_out_pop  = '0;
                n_out_gen  = '0;
            end
        end

        // line rotation once a row-end item is finished
        if (done) begin
            if ((r_state == S_IDLE) ? (i_entry.col == i_entry.last_col) : em_b) begin
                n_upper = r_lower;
                n_lower = n_cur;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_live      <= '0;
            r_gen       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_live      <= n_live;
            r_gen       <= n_gen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_row   <= i_entry.row;
            r_col   <= i_entry.col;
            r_lastc <= i_entry.last_col;
        end
        r_w0        <= n_w0;
        r_w1        <= n_w1;
        r_w2        <= n_w2;
        r_fidx      <= n_fidx;
        r_ecol      <= n_ecol;
        r_upper     <= n_upper;
        r_lower     <= n_lower;
        r_cur       <= n_cur;
        r_out_alive <= n_out_alive;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
        r_out_pop   <= n_out_pop;
        r_out_gen   <= n_out_gen;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), r_out_gen, r_out_pop,
                         r_out_col, r_out_row, r_out_alive};

    // the grid's closing result always ends its run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_last)
        else $error("grid end result without last flag");

    // the right-border cell is only emitted at the end of a row
    a_emit_b_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_B) |-> (r_col == r_lastc))
        else $error("right-border emission away from row end");

    // flush prefetch stays two columns ahead of the emitted column
    a_flush_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (r_fidx == FIDX_W'(r_ecol) + FIDX_W'(2)))
        else $error("flush window out of step");

    // population never exceeds a full grid
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= POP_W'(MAX_GRID * MAX_GRID))
        else $error("population counter overrun");

endmodule

`default_nettype wire

// File: rtl/life_generation_raster_engine_core.sv
// top level of the life generation raster engine: config registers and wiring
// depends on lgre_pkg, lgre_front, lgre_fifo, lgre_back
//
// Usage: cells of a square grid enter on the s_axis channel in raster order,
// one per beat (tdata bit 0 = alive). Each beat yields zero or more result
// beats on m_axis: a cell of the next generation with its row and column.
// From the second row on, every cell but a row's first releases the cell up
// and to the left; a row-end cell also releases the row above's last cell;
// the grid's final cell releases the whole bottom row, whose last beat carries
// tuser (grid done) plus population and the wrapped generation count. tlast
// marks the last result beat caused by an input beat. Configuration writes
// (side, wrap value) go over the cfg channel; the user must issue them only
// while the block is idle, as the block itself does not enforce this. The
// side takes effect at the next grid. The back end takes a new item from the
// queue only once it has emitted every result beat of the last one, and it
// prefetches in S_FILL before the bottom-row flush; a four-entry queue
// buffers input beats while it works. Reset clears position, counters and
// handshake state; line stores need no clearing. A stalled receiver holds
// the result register, the back end waits, the queue fills and then s_axis
// tready drops.
`default_nettype none

module life_generation_raster_engine_core
    import lgre_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // slave stream: [0] cell_alive, rest zero
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // master stream
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // [0] next_alive, [5:1] cell_row, [10:6] cell_col, [21:11] population,
    // [53:22] generation, rest zero
    output logic [OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                         o_m_axis_tlast,   // last_of_run
    output logic                         o_m_axis_tuser,   // grid_done
    // configuration write channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [SIZE_W-1:0] r_grid_size;
    logic [GEN_W-1:0]  r_max_gen;

    logic   push, full, pop, empty;
    t_entry push_entry, pop_entry;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_max_gen   <= MAX_GEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRID_SIZE: r_grid_size <= i_cfg_data[SIZE_W-1:0];
                REG_MAX_GEN:   r_max_gen   <= i_cfg_data[GEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    lgre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_alive     (i_s_axis_tdata[0]),
        .i_grid_size (r_grid_size),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // queue
    lgre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    // back end
    lgre_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_entry    (pop_entry),
        .o_pop      (pop),
        .i_max_gen  (r_max_gen),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
